### rtl/lpfr_pkg.sv
// Shared types and codes for the length-prefixed frame receiver.
package lpfr_pkg;

    // receive phases
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    // frame status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_BYTE    = 3'd1;
    localparam logic [2:0] ST_GOOD    = 3'd2;
    localparam logic [2:0] ST_LEN_ERR = 3'd3;
    localparam logic [2:0] ST_SUM_ERR = 3'd4;

    // configuration register indexes
    localparam logic CFG_START_DELIM = 1'b0;
    localparam logic CFG_MAX_LEN     = 1'b1;

    localparam logic [7:0] SUM_GOOD = 8'hFF;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        last_payload;
    } t_result;

endpackage

### rtl/lpfr_core.sv
// Frame parser state machine: one byte in, one result out, state advanced on accept.
module lpfr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic [7:0]       i_start_delimiter,
    input  logic [15:0]      i_max_payload_length,
    output lpfr_pkg::t_result o_result
);
    import lpfr_pkg::*;

    logic [2:0]  r_phase,        n_phase;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [7:0]  r_running_sum,  n_running_sum;

    logic [15:0] w_len_full;
    logic [16:0] w_count_inc;
    logic [7:0]  w_sum_add;
    t_result     w_res;

    assign w_len_full  = {r_frame_length[15:8], i_rx_byte};
    assign w_count_inc = {1'b0, r_byte_count} + 17'd1;
    assign w_sum_add   = r_running_sum + i_rx_byte;

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_byte_count   = r_byte_count;
        n_running_sum  = r_running_sum;
        w_res          = '0;
        w_res.frame_status = ST_NONE;
        case (r_phase)
            PH_LEN_HI: begin
                n_frame_length = {i_rx_byte, 8'd0};
                n_phase        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_frame_length = w_len_full;
                if (w_len_full > i_max_payload_length) begin
                    w_res.frame_status = ST_LEN_ERR;
                    n_phase            = PH_HUNT;
                end else begin
                    n_running_sum = 8'd0;
                    n_byte_count  = 16'd0;
                    n_phase       = (w_len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w_res.frame_status   = ST_BYTE;
                w_res.payload_byte   = i_rx_byte;
                w_res.payload_offset = r_byte_count;
                n_running_sum        = w_sum_add;
                if (w_count_inc >= {1'b0, r_frame_length}) begin
                    w_res.last_payload = 1'b1;
                    n_phase            = PH_CHECK;
                end
                n_byte_count = w_count_inc[15:0];
            end
            PH_CHECK: begin
                n_running_sum      = w_sum_add;
                w_res.frame_status = (w_sum_add == SUM_GOOD) ? ST_GOOD : ST_SUM_ERR;
                n_phase            = PH_HUNT;
            end
            default: begin
                // hunt, and any unused phase code: look for the delimiter
                n_phase = (i_rx_byte == i_start_delimiter) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_frame_length <= 16'd0;
            r_byte_count   <= 16'd0;
            r_running_sum  <= 8'd0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            r_running_sum  <= n_running_sum;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_count < r_frame_length))
        else $error("payload count reached frame length while still in payload");

    a_len_err_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_res.frame_status == ST_LEN_ERR) |=> (r_phase == PH_HUNT))
        else $error("length error did not return to hunt");

endmodule

### rtl/length_prefixed_frame_receiver.sv
// Top level of the length-prefixed frame receiver: config registers and output skid stage.
//
// Usage: feed one received byte per item on i_rx_byte with i_valid; o_stall
// high means hold the byte. Every accepted byte yields exactly one result on
// the output channel (o_valid / i_stall): status, payload byte, its offset and
// a last-byte flag. Status is nothing, payload byte, frame good, length error
// or checksum error. A frame is the start delimiter, a big-endian 16-bit
// length, the payload and one checksum byte; payload plus checksum must sum
// to 0xFF modulo 256.
// Each result is registered: in the output register, or the skid entry under a stall.
// Throughput: one byte per cycle while o_stall is low; the result register
// plus one skid entry take one more byte while the receiver stalls, and
// o_stall rises only once both are full.
// Reset (synchronous, active low): hunt for a delimiter, counters and sum
// cleared, delimiter 0x7E, maximum length 255, output stage empty.
// Configuration: i_cfg_we with i_cfg_index 0 (delimiter) or 1 (max length);
// write only while idle.
module length_prefixed_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_frame_status,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_offset,
    output logic        o_last_payload
);
    import lpfr_pkg::*;

    logic [7:0]  r_start_delimiter;
    logic [15:0] r_max_payload_length;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        w_in_accept;
    logic        w_out_free;
    t_result     w_result;

    assign o_stall     = r_skid_valid;
    assign w_in_accept = i_valid && !r_skid_valid;
    assign w_out_free  = !r_out_valid || !i_stall;

    lpfr_core u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (w_in_accept),
        .i_rx_byte            (i_rx_byte),
        .i_start_delimiter    (r_start_delimiter),
        .i_max_payload_length (r_max_payload_length),
        .o_result             (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delimiter    <= 8'd126;
            r_max_payload_length <= 16'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_DELIM: r_start_delimiter    <= i_cfg_wdata[7:0];
                CFG_MAX_LEN:     r_max_payload_length <= i_cfg_wdata;
                default:         r_max_payload_length <= r_max_payload_length;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            // drain the skid entry first, else take the new item
            r_out_valid  <= r_skid_valid || w_in_accept;
            r_skid_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_in_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_status   = r_out.frame_status;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_offset = r_out.payload_offset;
    assign o_last_payload   = r_out.last_payload;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_stalled_accept_skids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && w_in_accept) |=> r_skid_valid)
        else $error("item accepted under stall was not kept in skid entry");

endmodule

### dv/length_prefixed_frame_receiver_tb.sv
// Testbench for the length-prefixed frame receiver: random framed byte streams checked by a scoreboard.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_tb;
    import lpfr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 40;

    // Tracks the receive phase and predicts one result per accepted byte.
    class frame_scoreboard;
        logic [2:0]  phase;
        logic [15:0] frame_len;
        logic [15:0] byte_cnt;
        logic [7:0]  sum;
        logic [7:0]  delim;
        logic [15:0] max_len;
        t_result     expected_results[$];
        int          errors;

        function new();
            phase     = PH_HUNT;
            frame_len = '0;
            byte_cnt  = '0;
            sum       = '0;
            delim     = 8'h7E;
            max_len   = 16'd255;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] data);
            if (idx == CFG_START_DELIM) begin
                delim = data[7:0];
            end else begin
                max_len = data;
            end
        endfunction

        function void note_rx_byte(logic [7:0] b);
            t_result r;
            r = '0;
            r.frame_status = ST_NONE;
            case (phase)
                PH_LEN_HI: begin
                    frame_len = {b, 8'h00};
                    phase     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len[7:0] = b;
                    if (frame_len > max_len) begin
                        r.frame_status = ST_LEN_ERR;
                        phase          = PH_HUNT;
                    end else begin
                        sum      = '0;
                        byte_cnt = '0;
                        phase    = (frame_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    r.frame_status   = ST_BYTE;
                    r.payload_byte   = b;
                    r.payload_offset = byte_cnt;
                    sum              = sum + b;
                    if ({1'b0, byte_cnt} + 17'd1 >= {1'b0, frame_len}) begin
                        r.last_payload = 1'b1;
                        phase          = PH_CHECK;
                    end
                    byte_cnt = byte_cnt + 16'd1;
                end
                PH_CHECK: begin
                    sum            = sum + b;
                    r.frame_status = (sum == SUM_GOOD) ? ST_GOOD : ST_SUM_ERR;
                    phase          = PH_HUNT;
                end
                default: begin
                    phase = (b == delim) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, got.frame_status);
                return;
            end
            want = expected_results.pop_front();
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_offset", want.payload_offset, got.payload_offset);
            compare_field("last_payload", want.last_payload, got.last_payload);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_frame_status;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_offset;
    logic        o_last_payload;

    frame_scoreboard sb;
    bit          idle_on;
    int          sent;
    int          cycles;
    int          stall_left;
    logic [7:0]  cur_delim;
    logic [15:0] cur_max;

    length_prefixed_frame_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_payload_byte   (o_payload_byte),
        .o_payload_offset (o_payload_offset),
        .o_last_payload   (o_last_payload)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12 && cur_max != 16'hFFFF) begin
            if (r < 6) return cur_max + 16'd1;
            return 16'($urandom_range(int'(cur_max) + 1, 65535));
        end
        if (r < 20 && cur_max <= 16'd64) return cur_max;
        return 16'($urandom_range(0, (cur_max < 16'd12) ? int'(cur_max) : 12));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_rx_byte(b);
        sent++;
    endtask

    // Delimiter, big-endian length, payload and checksum; stop after the length if too long.
    task automatic send_frame(input logic [15:0] len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] chk;
        sum = '0;
        send_byte(cur_delim);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len > cur_max) return;
        for (int i = 0; i < int'(len); i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        chk = SUM_GOOD - sum;
        if (bad_sum) chk = chk + 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Hold the sender until every result is back.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        if (idx == CFG_START_DELIM) begin
            cur_delim = data[7:0];
        end else begin
            cur_max = data;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        int target;
        int r;
        target = sent + n_items;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(pick_len(), 1'b0);
            end else if (r < 85) begin
                send_frame(pick_len(), 1'b1);
            end else if (r < 98) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                drain();
            end
        end
    endtask

    // Receiver stalls in bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_frame_status, o_payload_byte, o_payload_offset, o_last_payload});
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("length_prefixed_frame_receiver_tb NOT OK");
            $finish;
        end
    end

    initial begin
        sb          = new();
        idle_on     = 1'b1;
        sent        = 0;
        cycles      = 0;
        stall_left  = 0;
        cur_delim   = 8'h7E;
        cur_max     = 16'd255;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_START_DELIM;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_stall     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hunt noise at both byte extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        // zero length, good then bad checksum
        send_byte(cur_delim); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
        send_byte(cur_delim); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        // single payload byte is also the last one
        send_byte(cur_delim); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'hAA); send_byte(8'h55);
        // payload byte extremes
        send_byte(cur_delim); send_byte(8'h00); send_byte(8'h02);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
        // lengths just over the limit and the largest one
        send_byte(cur_delim); send_byte(8'h01); send_byte(8'h00);
        send_byte(cur_delim); send_byte(8'hFF); send_byte(8'hFF);

        run_phase(200);

        drain();
        write_reg(CFG_START_DELIM, 16'h0000);
        write_reg(CFG_MAX_LEN, 16'h0000);
        run_phase(120);

        drain();
        write_reg(CFG_START_DELIM, 16'h00FF);
        write_reg(CFG_MAX_LEN, 16'hFFFF);
        run_phase(150);

        drain();
        write_reg(CFG_START_DELIM, 16'($urandom_range(0, 255)));
        write_reg(CFG_MAX_LEN, 16'd1);
        run_phase(120);

        drain();
        write_reg(CFG_START_DELIM, 16'h00A5);
        write_reg(CFG_MAX_LEN, 16'd20);
        idle_on = 1'b0;
        run_phase(60);
        idle_on = 1'b1;
        run_phase(140);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("length_prefixed_frame_receiver_tb OK");
        end else begin
            $display("length_prefixed_frame_receiver_tb NOT OK");
        end
        $finish;
    end

endmodule
